[rtl/shpf_pkg.sv]
// shared constants and types for the sparse high-pass pixel filter
`default_nettype none

package shpf_pkg;

  localparam int FRAME_SIZE_DEF = 192;
  localparam int TAP_STEP_DEF   = 4;
  localparam int PIXEL_BITS_DEF = 12;

  localparam int PIXEL_W = 12;
  localparam int VALUE_W = 16;
  localparam int COORD_W = 8;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [VALUE_W-1:0] BIAS_RESET = 16'd512;

  // register word index, taken from paddr[2]
  localparam logic REG_BIAS = 1'b0;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               border;
  } coord_t;

endpackage

`default_nettype wire

[rtl/shpf_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module shpf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/shpf_stencil.sv]
// column taps of the three stencil rows and the neighbour sum
`default_nettype none

module shpf_stencil #(
  parameter int TAP_STEP = 4,
  parameter int SAMPLE_W = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [SAMPLE_W-1:0]   samp_bot,
  input  wire logic [SAMPLE_W-1:0]   samp_mid,
  input  wire logic [SAMPLE_W-1:0]   samp_top,
  input  wire shpf_pkg::coord_t      in_coord,
  output logic                       out_valid,
  output logic [SAMPLE_W+2:0]        sum,
  output logic [SAMPLE_W-1:0]        centre,
  output shpf_pkg::coord_t           out_coord
);

  import shpf_pkg::*;

  localparam int TapLen = 2 * TAP_STEP;
  localparam int SumW   = SAMPLE_W + 3;

  logic [SAMPLE_W-1:0] sr_bot [TapLen];
  logic [SAMPLE_W-1:0] sr_mid [TapLen];
  logic [SAMPLE_W-1:0] sr_top [TapLen];
  logic [SumW-1:0]     sum_next;

  always_comb begin
    sum_next = SumW'(samp_bot) + SumW'(sr_bot[TAP_STEP-1]) + SumW'(sr_bot[TapLen-1])
             + SumW'(samp_mid) + SumW'(sr_mid[TapLen-1])
             + SumW'(samp_top) + SumW'(sr_top[TAP_STEP-1]) + SumW'(sr_top[TapLen-1]);
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      for (int i = TapLen - 1; i > 0; i--) begin
        sr_bot[i] <= sr_bot[i-1];
        sr_mid[i] <= sr_mid[i-1];
        sr_top[i] <= sr_top[i-1];
      end
      sr_bot[0] <= samp_bot;
      sr_mid[0] <= samp_mid;
      sr_top[0] <= samp_top;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum       <= sum_next;
      centre    <= sr_mid[TAP_STEP-1];
      out_coord <= in_coord;
    end
  end

endmodule

`default_nettype wire

[rtl/sparse_highpass_pixel_filter.sv]
// top level of the sparse high-pass pixel filter
//
//   port group   dir   content
//   s_*          in    pixel word, tuser marks frame start
//   m_*          out   filtered word with its row and column
//   p*           in    apb register port, bias at address 0
//
// one word in, one out per cycle unless stalled; s1, s2, stencil, output regs lead to m_tvalid
// two line rams (TAP_STEP*FRAME_SIZE deep) give the upper stencil rows, one access each a cycle
// the whole pipe moves when the output register is empty or taken; s_tready follows that
// rst clears counters, ram pointer, valid flags and sets bias to 512; ram holds no reset
`default_nettype none

module sparse_highpass_pixel_filter #(
  parameter int FRAME_SIZE = shpf_pkg::FRAME_SIZE_DEF,
  parameter int TAP_STEP   = shpf_pkg::TAP_STEP_DEF,
  parameter int PIXEL_BITS = shpf_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [15:0]                    s_tdata,  // pixel[11:0], zero
  input  wire logic                           s_tuser,  // frame_start
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [31:0]                         m_tdata,  // value[15:0], out_row, out_col
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [shpf_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [shpf_pkg::PDATA_W-1:0]   pwdata,
  output logic [shpf_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  import shpf_pkg::*;

  localparam int SampleW = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;
  localparam int SumW    = SampleW + 3;
  localparam int CntW    = $clog2(FRAME_SIZE);
  localparam int LineD   = TAP_STEP * FRAME_SIZE;
  localparam int PtrW    = $clog2(LineD);
  localparam logic [CntW-1:0] CntLast = CntW'(FRAME_SIZE - 1);
  localparam logic [CntW-1:0] TapC    = CntW'(TAP_STEP);
  localparam logic [CntW-1:0] HighC   = CntW'(FRAME_SIZE - TAP_STEP);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(LineD - 1);

  logic                en;
  logic                accept;
  logic [VALUE_W-1:0]  bias;
  logic [CntW-1:0]     row_count;
  logic [CntW-1:0]     col_count;
  logic [CntW-1:0]     row_cur;
  logic [CntW-1:0]     col_cur;
  logic [CntW-1:0]     orow;
  logic [CntW-1:0]     ocol;
  logic [CntW-1:0]     row_count_next;
  logic [CntW-1:0]     col_count_next;
  logic [PtrW-1:0]     ptr;
  logic [SampleW-1:0]  pix;
  coord_t              coord_next;

  logic                s1_valid;
  logic [SampleW-1:0]  s1_pix;
  logic [PtrW-1:0]     s1_ptr;
  coord_t              s1_coord;
  logic                s2_valid;
  logic [SampleW-1:0]  s2_pix;
  logic [SampleW-1:0]  s2_mid;
  coord_t              s2_coord;
  logic [SampleW-1:0]  ram0_rdata;
  logic [SampleW-1:0]  ram1_rdata;

  logic                s3_valid;
  logic [SumW-1:0]     s3_sum;
  logic [SampleW-1:0]  s3_centre;
  coord_t              s3_coord;
  logic [VALUE_W-1:0]  value_next;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && en;
  assign pix      = s_tdata[SampleW-1:0];

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BIAS) ? PDATA_W'(bias) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= BIAS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_BIAS) begin
      bias <= pwdata[VALUE_W-1:0];
    end
  end

  // raster position and output coordinates
  always_comb begin
    row_cur = s_tuser ? '0 : row_count;
    col_cur = s_tuser ? '0 : col_count;
    orow    = (row_cur >= TapC) ? row_cur - TapC : row_cur + HighC;
    ocol    = (col_cur >= TapC) ? col_cur - TapC : col_cur + HighC;
    coord_next.row    = COORD_W'(orow);
    coord_next.col    = COORD_W'(ocol);
    coord_next.border = (orow < TapC) || (orow >= HighC) || (ocol < TapC) || (ocol >= HighC);
    if (col_cur == CntLast) begin
      col_count_next = '0;
      row_count_next = (row_cur == CntLast) ? '0 : row_cur + 1'b1;
    end else begin
      col_count_next = col_cur + 1'b1;
      row_count_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      ptr       <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
    end else begin
      if (accept) begin
        row_count <= row_count_next;
        col_count <= col_count_next;
        ptr       <= (ptr == PtrLast) ? '0 : ptr + 1'b1;
      end
      if (en) begin
        s1_valid <= accept;
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pix   <= pix;
      s1_ptr   <= ptr;
      s1_coord <= coord_next;
      s2_pix   <= s1_pix;
      s2_mid   <= ram0_rdata;
      s2_coord <= s1_coord;
    end
  end

  // line delays, read before write at the same address
  shpf_ram #(
    .WIDTH (SampleW),
    .DEPTH (LineD)
  ) u_line0 (
    .clk   (clk),
    .we    (accept),
    .waddr (ptr),
    .wdata (pix),
    .re    (accept),
    .raddr (ptr),
    .rdata (ram0_rdata)
  );

  shpf_ram #(
    .WIDTH (SampleW),
    .DEPTH (LineD)
  ) u_line1 (
    .clk   (clk),
    .we    (en && s1_valid),
    .waddr (s1_ptr),
    .wdata (ram0_rdata),
    .re    (en && s1_valid),
    .raddr (s1_ptr),
    .rdata (ram1_rdata)
  );

  shpf_stencil #(
    .TAP_STEP (TAP_STEP),
    .SAMPLE_W (SampleW)
  ) u_stencil (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s2_valid),
    .samp_bot  (s2_pix),
    .samp_mid  (s2_mid),
    .samp_top  (ram1_rdata),
    .in_coord  (s2_coord),
    .out_valid (s3_valid),
    .sum       (s3_sum),
    .centre    (s3_centre),
    .out_coord (s3_coord)
  );

  // output register
  always_comb begin
    if (s3_coord.border) begin
      value_next = bias;
    end else begin
      value_next = bias + VALUE_W'(s3_centre) - VALUE_W'(s3_sum >> 3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {s3_coord.col, s3_coord.row, value_next};
    end
  end

endmodule

`default_nettype wire
